// ----- hdl/cs2rgb_pkg.sv -----
// shared types and constants for the colour model to rgb converter
// no dependencies; imported by every module of the block
package cs2rgb_pkg;

  // colour model codes carried in cmd
  localparam logic [1:0] CMD_RGB  = 2'd0;
  localparam logic [1:0] CMD_HSB  = 2'd1;
  localparam logic [1:0] CMD_CMYK = 2'd2;
  localparam logic [1:0] CMD_GRAY = 2'd3;

  // hue in 1/16 degree: sixty degrees per sector, invalid from 420 degrees
  localparam logic [13:0] HUE_SECTOR = 14'd960;
  localparam logic [13:0] HUE_LIMIT  = 14'd6720;
  localparam int unsigned NUM_SECTORS = 6;

  // 1600 * 960, the value of one for the term v * (1 - s*g/960)
  localparam logic [23:0] M_ONE = 24'd1536000;

  // final divide by 1600*1600*960 = 2^18 * 9375; the 9375 part is a
  // reciprocal multiply, exact for quotients below 2^22
  localparam logic [24:0] SAT_LIMIT   = 25'd2400000;  // 256 * 9375
  localparam logic [22:0] RECIP_9375  = 23'd7330078;  // ceil(2^36 / 9375)
  localparam int unsigned RECIP_SHIFT = 36;

  // one input beat
  typedef struct packed {
    logic [1:0]  cmd;
    logic [13:0] comp_a;
    logic [13:0] comp_b;
    logic [13:0] comp_c;
    logic [13:0] comp_d;
  } in_t;

  // one result beat
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       valid_res;
  } out_t;

  // per-stage load enables of the pipeline
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } stage_en_t;

  // information that rides alongside the hsb channel arithmetic
  typedef struct packed {
    logic [1:0] mode;
    logic [2:0] sector;
    logic       bad_hue;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } side_t;

  // first stage register contents
  typedef struct packed {
    side_t       side;
    logic [13:0] vv;
    logic [23:0] prod_p;
    logic [23:0] prod_q;
    logic [23:0] prod_t;
  } s1_t;

endpackage

// ----- hdl/cs2rgb_front.sv -----
// first pipeline stage: hue sector split, saturation products and the
// direct rgb, cmyk and gray channels; depends on cs2rgb_pkg
module cs2rgb_front (
  input  logic                  clk,
  input  cs2rgb_pkg::stage_en_t en,
  input  cs2rgb_pkg::in_t       data,
  output cs2rgb_pkg::s1_t       s1
);
  import cs2rgb_pkg::*;

  // floor or round x*255/4096, saturated to 255
  function automatic logic [7:0] scale_q12(logic [13:0] x, logic rnd);
    logic [21:0] p;
    p = 22'(x) * 22'd255 + (rnd ? 22'd2048 : 22'd0);
    return (p[21:12] > 10'd255) ? 8'hFF : p[19:12];
  endfunction

  // cmyk channel: max(0, 1 - x - k), rounded onto 0..255
  function automatic logic [7:0] cmyk_chan(logic [13:0] x, logic [13:0] k);
    logic [14:0] sum;
    logic [13:0] rem;
    sum = 15'(x) + 15'(k);
    rem = (sum >= 15'd4096) ? 14'd0 : 14'(15'd4096 - sum);
    return scale_q12(rem, 1'b1);
  endfunction

  logic [2:0]  sec;
  logic [13:0] sec_base;
  logic [9:0]  frac;
  s1_t         s1_next;

  // hue sector by threshold compare, fraction as remainder
  always_comb begin
    sec      = 3'd0;
    sec_base = 14'd0;
    for (int k = 1; k <= NUM_SECTORS; k++) begin
      if (data.comp_a >= 14'(k * HUE_SECTOR)) begin
        sec      = 3'(k);
        sec_base = 14'(k * HUE_SECTOR);
      end
    end
    frac = 10'(data.comp_a - sec_base);
  end

  // next contents of the stage register
  always_comb begin
    s1_next.side.mode    = data.cmd;
    s1_next.side.sector  = (sec == 3'(NUM_SECTORS)) ? 3'd0 : sec;
    s1_next.side.bad_hue = (data.comp_a >= HUE_LIMIT);
    s1_next.vv           = data.comp_c;
    s1_next.prod_p       = 24'(data.comp_b) * 24'(HUE_SECTOR);
    s1_next.prod_q       = 24'(data.comp_b) * 24'(frac);
    s1_next.prod_t       = 24'(data.comp_b) * 24'(10'(HUE_SECTOR) - frac);
    unique case (data.cmd)
      CMD_RGB: begin
        s1_next.side.red   = scale_q12(data.comp_a, 1'b0);
        s1_next.side.green = scale_q12(data.comp_b, 1'b0);
        s1_next.side.blue  = scale_q12(data.comp_c, 1'b0);
      end
      CMD_CMYK: begin
        s1_next.side.red   = cmyk_chan(data.comp_a, data.comp_d);
        s1_next.side.green = cmyk_chan(data.comp_b, data.comp_d);
        s1_next.side.blue  = cmyk_chan(data.comp_c, data.comp_d);
      end
      default: begin
        s1_next.side.red   = scale_q12(data.comp_a, 1'b1);
        s1_next.side.green = s1_next.side.red;
        s1_next.side.blue  = s1_next.side.red;
      end
    endcase
  end

  // stage register
  always_ff @(posedge clk) begin
    if (en.s1) begin
      s1 <= s1_next;
    end
  end

endmodule

// ----- hdl/cs2rgb_scale.sv -----
// one hsb channel, stages two to five: floor(255 * v * (1 - s*g/960))
// with clamp at zero and saturation at 255; depends on cs2rgb_pkg
module cs2rgb_scale (
  input  logic                  clk,
  input  cs2rgb_pkg::stage_en_t en,
  input  logic [13:0]           vv,
  input  logic [23:0]           prod,
  output logic [7:0]            ch
);
  import cs2rgb_pkg::*;

  logic [13:0] vv2;
  logic [20:0] m2;
  logic [34:0] p3;
  logic [42:0] n4;
  logic [24:0] x4_full;
  logic [21:0] x4;
  logic        sat4;
  logic [44:0] q5_full;
  logic [7:0]  q5;
  logic        sat5;

  // stage two: 1 - s*g, clamped at zero
  always_ff @(posedge clk) begin
    if (en.s2) begin
      vv2 <= vv;
      m2  <= (prod < M_ONE) ? 21'(M_ONE - prod) : 21'd0;
    end
  end

  // stage three: v times that term
  always_ff @(posedge clk) begin
    if (en.s3) begin
      p3 <= 35'(vv2) * 35'(m2);
    end
  end

  // stage four: times 255, drop the power-of-two part of the divisor
  assign n4      = {p3, 8'd0} - 43'(p3);
  assign x4_full = n4[42:18];

  always_ff @(posedge clk) begin
    if (en.s4) begin
      sat4 <= (x4_full >= SAT_LIMIT);
      x4   <= x4_full[21:0];
    end
  end

  // stage five: divide by 9375 through the reciprocal
  assign q5_full = 45'(x4) * 45'(RECIP_9375);

  always_ff @(posedge clk) begin
    if (en.s5) begin
      sat5 <= sat4;
      q5   <= q5_full[RECIP_SHIFT+7:RECIP_SHIFT];
    end
  end

  assign ch = sat5 ? 8'hFF : q5;

endmodule

// ----- hdl/color_space_to_rgb.sv -----
// Converts one colour per beat from rgb, hsb, cmyk or gray into 8-bit rgb.
// A beat may be accepted every clock cycle while the output side does not stall;
// its result passes the register stages below and then the output register.
// The pipeline depth is set by the hsb path: sector split and saturation products,
// clamp, value multiply, scale by 255, and a reciprocal multiply for the
// final divide, each in a register stage of its own. A stall on the output
// holds each full stage with no empty stage after it and lets empty stages fill behind it.
// depends on cs2rgb_pkg, cs2rgb_front and cs2rgb_scale
module color_space_to_rgb (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  cs2rgb_pkg::in_t  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output cs2rgb_pkg::out_t out_data
);
  import cs2rgb_pkg::*;

  stage_en_t en;
  logic      v1, v2, v3, v4, v5;
  logic      adv_o;
  s1_t       s1;
  side_t     side2, side3, side4, side5;
  logic [7:0] ch_v, ch_p, ch_q, ch_t;
  out_t      result_next;

  // stage load enables: a stage loads when empty or when it drains
  assign adv_o = !out_valid || out_ready;
  assign en.s5 = !v5 || adv_o;
  assign en.s4 = !v4 || en.s5;
  assign en.s3 = !v3 || en.s4;
  assign en.s2 = !v2 || en.s3;
  assign en.s1 = !v1 || en.s2;
  assign in_ready = en.s1;

  // valid bits travelling with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      v5        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en.s1) v1 <= in_valid;
      if (en.s2) v2 <= v1;
      if (en.s3) v3 <= v2;
      if (en.s4) v4 <= v3;
      if (en.s5) v5 <= v4;
      if (adv_o) out_valid <= v5;
    end
  end

  cs2rgb_front u_front (
    .clk  (clk),
    .en   (en),
    .data (in_data),
    .s1   (s1)
  );

  // the four hsb candidates: v, p, q and t
  cs2rgb_scale u_scale_v (.clk(clk), .en(en), .vv(s1.vv), .prod(24'd0),     .ch(ch_v));
  cs2rgb_scale u_scale_p (.clk(clk), .en(en), .vv(s1.vv), .prod(s1.prod_p), .ch(ch_p));
  cs2rgb_scale u_scale_q (.clk(clk), .en(en), .vv(s1.vv), .prod(s1.prod_q), .ch(ch_q));
  cs2rgb_scale u_scale_t (.clk(clk), .en(en), .vv(s1.vv), .prod(s1.prod_t), .ch(ch_t));

  // side information alongside the channel arithmetic
  always_ff @(posedge clk) begin
    if (en.s2) side2 <= s1.side;
    if (en.s3) side3 <= side2;
    if (en.s4) side4 <= side3;
    if (en.s5) side5 <= side4;
  end

  // pick the result by colour model and hue sector
  always_comb begin
    result_next.red       = side5.red;
    result_next.green     = side5.green;
    result_next.blue      = side5.blue;
    result_next.valid_res = 1'b1;
    if (side5.mode == CMD_HSB) begin
      if (side5.bad_hue) begin
        result_next.red       = 8'd0;
        result_next.green     = 8'd0;
        result_next.blue      = 8'd0;
        result_next.valid_res = 1'b0;
      end else begin
        unique case (side5.sector)
          3'd0: begin
            result_next.red = ch_v; result_next.green = ch_t; result_next.blue = ch_p;
          end
          3'd1: begin
            result_next.red = ch_q; result_next.green = ch_v; result_next.blue = ch_p;
          end
          3'd2: begin
            result_next.red = ch_p; result_next.green = ch_v; result_next.blue = ch_t;
          end
          3'd3: begin
            result_next.red = ch_p; result_next.green = ch_q; result_next.blue = ch_v;
          end
          3'd4: begin
            result_next.red = ch_t; result_next.green = ch_p; result_next.blue = ch_v;
          end
          default: begin
            result_next.red = ch_v; result_next.green = ch_p; result_next.blue = ch_q;
          end
        endcase
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (adv_o) begin
      out_data <= result_next;
    end
  end

`ifndef NO_ASSERTIONS
  // an invalid hue always comes out as black
  a_bad_is_black: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.valid_res |->
      out_data.red == 8'd0 && out_data.green == 8'd0 && out_data.blue == 8'd0)
    else $error("invalid hue result is not black");

  // only the hsb model may flag a result as invalid
  a_other_valid: assert property (@(posedge clk) disable iff (rst)
    v5 && adv_o && side5.mode != CMD_HSB |=> out_data.valid_res)
    else $error("non-hsb result flagged invalid");

  // a valid hsb result carries the brightness channel somewhere
  a_hsb_has_v: assert property (@(posedge clk) disable iff (rst)
    v5 && adv_o && side5.mode == CMD_HSB && !side5.bad_hue |=>
      out_data.red == $past(ch_v) || out_data.green == $past(ch_v) ||
      out_data.blue == $past(ch_v))
    else $error("hsb result lacks the brightness channel");

  // a full stage three that cannot drain keeps its beat
  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    v3 && !en.s3 |=> v3)
    else $error("stalled beat lost in stage three");
`endif

endmodule
